/* hdl/chse_pkg.sv */
// chse_pkg: shared types and codes for the cuckoo hash set engine.
// No dependencies; imported by every module of the block.

package chse_pkg;

    // Field widths fixed by the interface
    localparam int KEY_W   = 32;
    localparam int CFG_W   = 10;
    localparam int ENTRY_W = KEY_W + 1;   // valid bit on top of the key

    // Request codes
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_DISP = 2'd0;
    localparam logic [1:0] REG_SEED_A   = 2'd1;
    localparam logic [1:0] REG_SEED_B   = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] MAX_DISP_RST = 10'd100;
    localparam logic [CFG_W-1:0] SEED_A_RST   = 10'd0;
    localparam logic [CFG_W-1:0] SEED_B_RST   = 10'd1;

    // Configuration handed from the register file to the sequencer
    typedef struct packed {
        logic [CFG_W-1:0] max_disp;
        logic [CFG_W-1:0] seed_a;
        logic [CFG_W-1:0] seed_b;
    } cfg_t;

endpackage

/* hdl/chse_table.sv */
// chse_table: one hash table, a single-write, single-read memory with registered read data.
// Depends on chse_pkg for the entry width.

module chse_table
    import chse_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [ENTRY_W-1:0]        wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [ENTRY_W-1:0]        rd_data
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/chse_seq.sv */
// chse_seq: request sequencer with one shared key comparator, clearing pass and result register.
// Depends on chse_pkg; drives the ports of the two chse_table memories.

module chse_seq
    import chse_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cfg_t                            cfg,
    // request beat
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_op,
    input  logic [KEY_W-1:0]                s_key,
    // result beat
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_success,
    output logic                            m_table_full,
    output logic [KEY_W-1:0]                m_homeless_key,
    // table A
    output logic                            a_wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]  a_wr_addr,
    output logic [ENTRY_W-1:0]              a_wr_data,
    output logic                            a_rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]  a_rd_addr,
    input  logic [ENTRY_W-1:0]              a_rd_data,
    // table B
    output logic                            b_wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]  b_wr_addr,
    output logic [ENTRY_W-1:0]              b_wr_data,
    output logic                            b_rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]  b_rd_addr,
    input  logic [ENTRY_W-1:0]              b_rd_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LOOK_A = 3'd2;
    localparam logic [2:0] ST_LOOK_B = 3'd3;
    localparam logic [2:0] ST_INS_A  = 3'd4;
    localparam logic [2:0] ST_INS_B  = 3'd5;
    localparam logic [2:0] ST_RESP   = 3'd6;

    localparam logic [AW-1:0]      CLR_LAST = AW'(TABLE_DEPTH - 1);
    localparam logic [ENTRY_W-1:0] EMPTY    = '0;

    // slot = low bits of (key xor seed)
    function automatic logic [AW-1:0] slot(input logic [KEY_W-1:0] k,
                                           input logic [CFG_W-1:0] s);
        logic [KEY_W-1:0] s_ext;
        s_ext = {{(KEY_W-CFG_W){1'b0}}, s};
        return k[AW-1:0] ^ s_ext[AW-1:0];
    endfunction

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [1:0]        op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;     // request key, then the key being placed
    logic [KEY_W-1:0]  ev_reg, ev_next;       // key pushed out of table A
    logic [AW-1:0]     addr_a_reg, addr_a_next;
    logic [AW-1:0]     addr_b_reg, addr_b_next;
    logic [CFG_W-1:0]  round_reg, round_next;
    logic              res_succ_reg, res_succ_next;
    logic              res_full_reg, res_full_next;
    logic [KEY_W-1:0]  res_home_reg, res_home_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_succ_reg, m_succ_next;
    logic              m_full_reg, m_full_next;
    logic [KEY_W-1:0]  m_home_reg, m_home_next;

    // Shared comparator: A entry in LOOK_A, B entry in LOOK_B
    logic [ENTRY_W-1:0] cmp_entry;
    logic               hit;
    logic [CFG_W-1:0]   round_inc;

    assign cmp_entry = (state_reg == ST_LOOK_B) ? b_rd_data : a_rd_data;
    assign hit       = cmp_entry[KEY_W] && (cmp_entry[KEY_W-1:0] == key_reg);
    assign round_inc = CFG_W'(round_reg + 1'b1);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        ev_next       = ev_reg;
        addr_a_next   = addr_a_reg;
        addr_b_next   = addr_b_reg;
        round_next    = round_reg;
        res_succ_next = res_succ_reg;
        res_full_next = res_full_reg;
        res_home_next = res_home_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_succ_next   = m_succ_reg;
        m_full_next   = m_full_reg;
        m_home_next   = m_home_reg;

        a_wr_en   = 1'b0;
        a_wr_addr = addr_a_reg;
        a_wr_data = EMPTY;
        a_rd_en   = 1'b0;
        a_rd_addr = addr_a_reg;
        b_wr_en   = 1'b0;
        b_wr_addr = addr_b_reg;
        b_wr_data = EMPTY;
        b_rd_en   = 1'b0;
        b_rd_addr = addr_b_reg;

        case (state_reg)
            // empty every entry of both tables, one row a cycle
            ST_CLEAR: begin
                a_wr_en   = 1'b1;
                a_wr_addr = clr_reg;
                b_wr_en   = 1'b1;
                b_wr_addr = clr_reg;
                clr_next  = AW'(clr_reg + 1'b1);
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end

            // take a request, read both candidate slots
            ST_IDLE: begin
                if (s_valid) begin
                    op_next       = s_op;
                    key_next      = s_key;
                    addr_a_next   = slot(s_key, cfg.seed_a);
                    addr_b_next   = slot(s_key, cfg.seed_b);
                    a_rd_en       = 1'b1;
                    a_rd_addr     = slot(s_key, cfg.seed_a);
                    b_rd_en       = 1'b1;
                    b_rd_addr     = slot(s_key, cfg.seed_b);
                    res_succ_next = 1'b0;
                    res_full_next = 1'b0;
                    res_home_next = '0;
                    if (s_op == OP_LOOKUP || s_op == OP_INSERT || s_op == OP_REMOVE) begin
                        state_next = ST_LOOK_A;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end

            // compare against the table A slot
            ST_LOOK_A: begin
                if (hit) begin
                    res_succ_next = (op_reg != OP_INSERT);
                    a_wr_en       = (op_reg == OP_REMOVE);
                    state_next    = ST_RESP;
                end else begin
                    state_next = ST_LOOK_B;
                end
            end

            // compare against the table B slot
            ST_LOOK_B: begin
                if (hit) begin
                    res_succ_next = (op_reg != OP_INSERT);
                    b_wr_en       = (op_reg == OP_REMOVE);
                    state_next    = ST_RESP;
                end else if (op_reg != OP_INSERT) begin
                    state_next = ST_RESP;
                end else if (cfg.max_disp == '0) begin
                    res_full_next = 1'b1;
                    res_home_next = key_reg;
                    state_next    = ST_RESP;
                end else begin
                    round_next = '0;
                    a_rd_en    = 1'b1;
                    a_rd_addr  = addr_a_reg;
                    state_next = ST_INS_A;
                end
            end

            // place key in A, push the occupant toward B
            ST_INS_A: begin
                a_wr_en   = 1'b1;
                a_wr_data = {1'b1, key_reg};
                if (!a_rd_data[KEY_W]) begin
                    res_succ_next = 1'b1;
                    state_next    = ST_RESP;
                end else begin
                    ev_next     = a_rd_data[KEY_W-1:0];
                    addr_b_next = slot(a_rd_data[KEY_W-1:0], cfg.seed_b);
                    b_rd_en     = 1'b1;
                    b_rd_addr   = slot(a_rd_data[KEY_W-1:0], cfg.seed_b);
                    state_next  = ST_INS_B;
                end
            end

            // place pushed key in B, the B occupant goes round again
            ST_INS_B: begin
                b_wr_en   = 1'b1;
                b_wr_data = {1'b1, ev_reg};
                if (!b_rd_data[KEY_W]) begin
                    res_succ_next = 1'b1;
                    state_next    = ST_RESP;
                end else if (round_inc == cfg.max_disp) begin
                    res_full_next = 1'b1;
                    res_home_next = b_rd_data[KEY_W-1:0];
                    state_next    = ST_RESP;
                end else begin
                    key_next    = b_rd_data[KEY_W-1:0];
                    round_next  = round_inc;
                    addr_a_next = slot(b_rd_data[KEY_W-1:0], cfg.seed_a);
                    a_rd_en     = 1'b1;
                    a_rd_addr   = slot(b_rd_data[KEY_W-1:0], cfg.seed_a);
                    state_next  = ST_INS_A;
                end
            end

            // hand the result to the output register once it is free
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_succ_next  = res_succ_reg;
                    m_full_next  = res_full_reg;
                    m_home_next  = res_home_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        ev_reg       <= ev_next;
        addr_a_reg   <= addr_a_next;
        addr_b_reg   <= addr_b_next;
        round_reg    <= round_next;
        res_succ_reg <= res_succ_next;
        res_full_reg <= res_full_next;
        res_home_reg <= res_home_next;
        m_succ_reg   <= m_succ_next;
        m_full_reg   <= m_full_next;
        m_home_reg   <= m_home_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_success      = m_succ_reg;
    assign m_table_full   = m_full_reg;
    assign m_homeless_key = m_home_reg;

endmodule

/* hdl/cuckoo_hash_set_engine.sv */
// cuckoo_hash_set_engine: top level, configuration registers, sequencer and two hash tables.
// Depends on chse_pkg, chse_table and chse_seq.
//
//   channel   beat                              handshake
//   s_        op, key (request)                 s_valid / s_ready
//   m_        success, table_full, homeless_key m_valid / m_ready
//   cfg_      index, wdata (register write)     cfg_wr_en, no wait
//
// One request at a time; s_ready is high only while the sequencer is idle.
// An unused op goes straight to the result. Lookup, remove and duplicate insert finish
// on a table-A hit, else after the table-B compare. A new-key insert runs displacement
// rounds, one table-A and one table-B access per round, until a key settles in an empty
// slot or max_displacements rounds are done. A stalled m_ready holds the result
// register; the next request is still taken while it waits. After reset a clearing
// pass empties both tables before the first request is taken.

module cuckoo_hash_set_engine
    import chse_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // request channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_op,
    input  logic signed [KEY_W-1:0]  s_key,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_success,
    output logic                     m_table_full,
    output logic signed [KEY_W-1:0]  m_homeless_key,
    // configuration write port
    input  logic                     cfg_wr_en,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);

    cfg_t cfg_reg, cfg_next;

    logic               a_wr_en, a_rd_en, b_wr_en, b_rd_en;
    logic [AW-1:0]      a_wr_addr, a_rd_addr, b_wr_addr, b_rd_addr;
    logic [ENTRY_W-1:0] a_wr_data, a_rd_data, b_wr_data, b_rd_data;
    logic [KEY_W-1:0]   home_key;

    // Configuration register file
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAX_DISP: cfg_next.max_disp = cfg_wdata;
                REG_SEED_A:   cfg_next.seed_a   = cfg_wdata;
                REG_SEED_B:   cfg_next.seed_b   = cfg_wdata;
                default:      cfg_next          = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_disp <= MAX_DISP_RST;
            cfg_reg.seed_a   <= SEED_A_RST;
            cfg_reg.seed_b   <= SEED_B_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer
    chse_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_key          (s_key),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_success      (m_success),
        .m_table_full   (m_table_full),
        .m_homeless_key (home_key),
        .a_wr_en        (a_wr_en),
        .a_wr_addr      (a_wr_addr),
        .a_wr_data      (a_wr_data),
        .a_rd_en        (a_rd_en),
        .a_rd_addr      (a_rd_addr),
        .a_rd_data      (a_rd_data),
        .b_wr_en        (b_wr_en),
        .b_wr_addr      (b_wr_addr),
        .b_wr_data      (b_wr_data),
        .b_rd_en        (b_rd_en),
        .b_rd_addr      (b_rd_addr),
        .b_rd_data      (b_rd_data)
    );

    assign m_homeless_key = home_key;

    // Hash tables
    chse_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table_a (
        .aclk    (aclk),
        .wr_en   (a_wr_en),
        .wr_addr (a_wr_addr),
        .wr_data (a_wr_data),
        .rd_en   (a_rd_en),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    chse_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table_b (
        .aclk    (aclk),
        .wr_en   (b_wr_en),
        .wr_addr (b_wr_addr),
        .wr_data (b_wr_data),
        .rd_en   (b_rd_en),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

endmodule
